// ----- sv/dia_pkg.sv -----
// Shared constants, types and helpers for the dense id assigner.
`timescale 1ns / 1ps
package dia_pkg;

    localparam int HASH_ENTRIES = 512;
    localparam int HASH_W       = $clog2(HASH_ENTRIES);
    localparam int BLOCK_SLOTS  = 4;
    localparam int SLOT_W       = $clog2(BLOCK_SLOTS);
    localparam int MAX_IDS      = 4096;
    localparam int ID_W         = 12;
    localparam int CNT_W        = 13;
    localparam int POOL_BLOCKS  = 1024;
    localparam int BLK_W        = $clog2(POOL_BLOCKS);
    localparam int BLKCNT_W     = BLK_W + 1;
    localparam int KEY_W        = 24;
    localparam int TAG_W        = 13;
    localparam int TBL_DEPTH    = HASH_ENTRIES + POOL_BLOCKS * BLOCK_SLOTS;
    localparam int TBL_AW       = $clog2(TBL_DEPTH);
    localparam int TBL_DW       = KEY_W + TAG_W;

    // Slot tags: empty, link to an overflow block, anything else is an id.
    localparam logic [TAG_W-1:0] TAG_EMPTY = {TAG_W{1'b1}};
    localparam logic [TAG_W-1:0] TAG_LINK  = {{(TAG_W-1){1'b1}}, 1'b0};

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_CHK,
        ST_FILL_NEXT,
        ST_ALLOC0,
        ST_ALLOC1,
        ST_ALLOC2,
        ST_RD_CHK,
        ST_DONE
    } dia_state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key_out;
        logic             is_new;
        logic             full_res;
        logic [CNT_W-1:0] count;
    } dia_res_t;

    // Table address of a slot inside an overflow block.
    function automatic logic [TBL_AW-1:0] pool_addr(input logic [BLK_W-1:0] blk,
                                                    input logic [SLOT_W-1:0] slot);
        pool_addr = TBL_AW'(HASH_ENTRIES) + TBL_AW'({blk, slot});
    endfunction

endpackage

// ----- sv/dia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dia_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/dia_ctrl.sv -----
// Sequencer that walks hash chains, allocates blocks and assigns ids.
`timescale 1ns / 1ps
module dia_ctrl import dia_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [ID_W-1:0]    in_index,
    output logic               res_valid,
    input  logic               res_ready,
    output dia_res_t           res,
    output logic               tbl_we,
    output logic [TBL_AW-1:0]  tbl_waddr,
    output logic [TBL_DW-1:0]  tbl_wdata,
    output logic [TBL_AW-1:0]  tbl_raddr,
    input  logic [TBL_DW-1:0]  tbl_rdata,
    output logic               ord_we,
    output logic [ID_W-1:0]    ord_waddr,
    output logic [KEY_W-1:0]   ord_wdata,
    output logic [ID_W-1:0]    ord_raddr,
    input  logic [KEY_W-1:0]   ord_rdata
);

    dia_state_t           state_reg, state_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [TBL_AW-1:0]    cur_reg, cur_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 in_blk_reg, in_blk_next;
    logic [TBL_DW-1:0]    old_reg, old_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [KEY_W-1:0]     kout_reg, kout_next;
    logic                 new_reg, new_next;
    logic                 full_reg, full_next;
    logic [CNT_W-1:0]     next_id_reg, next_id_nx;
    logic [BLKCNT_W-1:0]  next_blk_reg, next_blk_nx;
    logic [HASH_W-1:0]    clr_reg, clr_next;
    logic                 reply_reg, reply_next;

    logic [KEY_W-1:0]     rd_key;
    logic [TAG_W-1:0]     rd_tag;
    logic                 is_last;
    logic                 ids_out;
    logic                 blks_out;

    assign rd_key   = tbl_rdata[TBL_DW-1:TAG_W];
    assign rd_tag   = tbl_rdata[TAG_W-1:0];
    assign is_last  = !in_blk_reg || (slot_reg == SLOT_W'(BLOCK_SLOTS - 1));
    assign ids_out  = next_id_reg >= CNT_W'(MAX_IDS);
    assign blks_out = next_blk_reg >= BLKCNT_W'(POOL_BLOCKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            next_id_reg  <= '0;
            next_blk_reg <= '0;
            clr_reg      <= '0;
            reply_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            next_id_reg  <= next_id_nx;
            next_blk_reg <= next_blk_nx;
            clr_reg      <= clr_next;
            reply_reg    <= reply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        in_blk_reg <= in_blk_next;
        old_reg    <= old_next;
        blk_reg    <= blk_next;
        id_reg     <= id_next;
        kout_reg   <= kout_next;
        new_reg    <= new_next;
        full_reg   <= full_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        slot_next   = slot_reg;
        in_blk_next = in_blk_reg;
        old_next    = old_reg;
        blk_next    = blk_reg;
        id_next     = id_reg;
        kout_next   = kout_reg;
        new_next    = new_reg;
        full_next   = full_reg;
        next_id_nx  = next_id_reg;
        next_blk_nx = next_blk_reg;
        clr_next    = clr_reg;
        reply_next  = reply_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = cur_reg;
        tbl_wdata = '0;
        tbl_raddr = cur_reg;
        ord_we    = 1'b0;
        ord_waddr = next_id_reg[ID_W-1:0];
        ord_wdata = key_reg;
        ord_raddr = in_index;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the head slots to empty, one a cycle.
                tbl_we    = 1'b1;
                tbl_waddr = TBL_AW'(clr_reg);
                tbl_wdata = {{KEY_W{1'b0}}, TAG_EMPTY};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == HASH_W'(HASH_ENTRIES - 1))
                begin
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
                    reply_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                tbl_raddr = TBL_AW'(in_key[HASH_W-1:0]);
                if (in_valid)
                begin
                    key_next    = in_key;
                    cur_next    = TBL_AW'(in_key[HASH_W-1:0]);
                    slot_next   = '0;
                    in_blk_next = 1'b0;
                    id_next     = '0;
                    kout_next   = '0;
                    new_next    = 1'b0;
                    full_next   = 1'b0;
                    case (in_op)
                        OP_MAP:
                        begin
                            state_next = ST_MAP_CHK;
                        end
                        OP_READ:
                        begin
                            state_next = (CNT_W'(in_index) < next_id_reg) ? ST_RD_CHK
                                                                           : ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            next_id_nx  = '0;
                            next_blk_nx = '0;
                            clr_next    = '0;
                            reply_next  = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MAP_CHK:
            begin
                if (rd_tag == TAG_EMPTY)
                begin
                    if (ids_out)
                    begin
                        full_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        tbl_we     = 1'b1;
                        tbl_wdata  = {key_reg, TAG_W'(next_id_reg)};
                        ord_we     = 1'b1;
                        id_next    = next_id_reg[ID_W-1:0];
                        new_next   = 1'b1;
                        next_id_nx = next_id_reg + 1'b1;
                        state_next = is_last ? ST_DONE : ST_FILL_NEXT;
                    end
                end
                else if (rd_tag == TAG_LINK)
                begin
                    // Follow the link into slot 0 of the block.
                    cur_next    = pool_addr(rd_key[BLK_W-1:0], '0);
                    tbl_raddr   = pool_addr(rd_key[BLK_W-1:0], '0);
                    slot_next   = '0;
                    in_blk_next = 1'b1;
                end
                else if (rd_key == key_reg)
                begin
                    id_next    = rd_tag[ID_W-1:0];
                    state_next = ST_DONE;
                end
                else if (!is_last)
                begin
                    cur_next  = cur_reg + 1'b1;
                    tbl_raddr = cur_reg + 1'b1;
                    slot_next = slot_reg + 1'b1;
                end
                else if (ids_out || blks_out)
                begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // Turn this slot into a link and move its entry to a new block.
                    tbl_we      = 1'b1;
                    tbl_wdata   = {KEY_W'(next_blk_reg), TAG_LINK};
                    ord_we      = 1'b1;
                    old_next    = tbl_rdata;
                    blk_next    = next_blk_reg[BLK_W-1:0];
                    id_next     = next_id_reg[ID_W-1:0];
                    new_next    = 1'b1;
                    next_id_nx  = next_id_reg + 1'b1;
                    next_blk_nx = next_blk_reg + 1'b1;
                    state_next  = ST_ALLOC0;
                end
            end
            ST_FILL_NEXT:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = cur_reg + 1'b1;
                tbl_wdata  = {{KEY_W{1'b0}}, TAG_EMPTY};
                state_next = ST_DONE;
            end
            ST_ALLOC0:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = pool_addr(blk_reg, SLOT_W'(0));
                tbl_wdata  = old_reg;
                state_next = ST_ALLOC1;
            end
            ST_ALLOC1:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = pool_addr(blk_reg, SLOT_W'(1));
                tbl_wdata  = {key_reg, TAG_W'(id_reg)};
                state_next = ST_ALLOC2;
            end
            ST_ALLOC2:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = pool_addr(blk_reg, SLOT_W'(2));
                tbl_wdata  = {{KEY_W{1'b0}}, TAG_EMPTY};
                state_next = ST_DONE;
            end
            ST_RD_CHK:
            begin
                kout_next  = ord_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.id       = id_reg;
    assign res.key_out  = kout_reg;
    assign res.is_new   = new_reg;
    assign res.full_res = full_reg;
    assign res.count    = next_id_reg;

endmodule

// ----- sv/dense_id_assigner.sv -----
// Top level of the dense id assigner: sequencer, table memories, output register.
//
//  channel  | dir | tdata (low bit up)                                   | tuser
//  ---------+-----+------------------------------------------------------+---------
//  s_axis   | in  | key[23:0], index[35:24], zero fill to 40 bits        | op[1:0]
//  m_axis   | out | id[11:0], key_out[35:12], is_new[36], full_res[37],  | -
//           |     | count[50:38], zero fill to 56 bits                   |
//
// Steps: a map reads the head slot and walks the chain slot by slot; a free slot
// takes the key, the next slot marked empty unless the chain ends there, and a
// full chain end becomes a link to a new overflow block, filled in ALLOC0-ALLOC2.
// A read fetches the key of an index below the count. Reset and clear sweep the
// 512 head slots, one a cycle; no item is accepted during the sweep. A finished
// result waits in the output register while the next item is taken; the sequencer
// holds only when a second result is ready before the first has been taken.
`timescale 1ns / 1ps
module dense_id_assigner import dia_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[23:0], index[35:24]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // id, key_out, is_new, full_res, count
);

    dia_res_t            res;
    logic                res_valid;
    logic                res_ready;
    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_waddr;
    logic [TBL_DW-1:0]   tbl_wdata;
    logic [TBL_AW-1:0]   tbl_raddr;
    logic [TBL_DW-1:0]   tbl_rdata;
    logic                ord_we;
    logic [ID_W-1:0]     ord_waddr;
    logic [KEY_W-1:0]    ord_wdata;
    logic [ID_W-1:0]     ord_raddr;
    logic [KEY_W-1:0]    ord_rdata;
    logic                out_valid_reg, out_valid_next;
    dia_res_t            out_reg, out_next;

    // Output slot free when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || m_tready;

    dia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_key    (s_tdata[KEY_W-1:0]),
        .in_index  (s_tdata[KEY_W+ID_W-1:KEY_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .ord_we    (ord_we),
        .ord_waddr (ord_waddr),
        .ord_wdata (ord_wdata),
        .ord_raddr (ord_raddr),
        .ord_rdata (ord_rdata)
    );

    // Head slots followed by overflow block slots, each {key, tag}.
    dia_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (TBL_DW)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Key of each assigned id, in order of assignment.
    dia_ram #(
        .DEPTH (MAX_IDS),
        .WIDTH (KEY_W)
    ) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.count, out_reg.full_res, out_reg.is_new,
                       out_reg.key_out, out_reg.id};

endmodule

// ----- verif/tb_dense_id_assigner.sv -----
// Self-checking testbench for the dense id assigner: directed, table fill and random traffic.
`timescale 1ns / 1ps
module tb_dense_id_assigner;
    import dia_pkg::*;

    // Unused opcode: the block must leave its state alone and report only the count.
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT = 20000;   // covers the clear sweep and the longest chain walk
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key_out;
        logic             is_new;
        logic             full_res;
        logic [CNT_W-1:0] count;
    } id_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // key[23:0], index[35:24], zero fill
    logic [1:0]  s_tuser;    // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // id[11:0], key_out[35:12], is_new[36], full_res[37], count[50:38]

    dense_id_assigner u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow of the chain table: head slots first, then the overflow blocks,
    // the same flat layout the block uses.
    logic [TAG_W-1:0] shadow_tag [TBL_DEPTH];
    logic [KEY_W-1:0] shadow_key [TBL_DEPTH];
    logic [KEY_W-1:0] id_to_key  [MAX_IDS];
    int               ids_used;
    int               blocks_used;

    id_result_t       pending_results[$];
    logic [KEY_W-1:0] recent_keys[$];
    int               mismatches;
    int               stall_cycles;
    bit               idle_on;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Empty every head slot and restart ids and blocks.
    function automatic void shadow_clear();
        for (int h = 0; h < HASH_ENTRIES; h++)
            shadow_tag[h] = TAG_EMPTY;
        ids_used = 0;
        blocks_used = 0;
    endfunction

    // Walk the chain for one key; insert it if unseen. Returns 0 when out of room.
    function automatic bit lookup_or_insert(input logic [KEY_W-1:0] k,
                                            output logic [ID_W-1:0] id_o,
                                            output logic fresh);
        int base;
        int slot;
        int last;
        int idx;
        int nb;
        logic [TAG_W-1:0] tg;
        base = int'(k) % HASH_ENTRIES;
        slot = 0;
        last = 0;
        id_o = '0;
        fresh = 1'b0;
        for (int guard = 0; guard < TBL_DEPTH + 4; guard++)
        begin
            idx = base + slot;
            tg = shadow_tag[idx];
            if (tg == TAG_EMPTY)
            begin
                if (ids_used >= MAX_IDS)
                    return 1'b0;
                shadow_tag[idx] = TAG_W'(ids_used);
                shadow_key[idx] = k;
                id_to_key[ids_used] = k;
                // Mark the slot after this one empty, inside a block only.
                if (slot != last)
                    shadow_tag[idx + 1] = TAG_EMPTY;
                id_o = ID_W'(ids_used);
                ids_used++;
                fresh = 1'b1;
                return 1'b1;
            end
            else if (tg == TAG_LINK)
            begin
                if (int'(shadow_key[idx]) >= POOL_BLOCKS)
                    return 1'b0;
                base = HASH_ENTRIES + int'(shadow_key[idx]) * BLOCK_SLOTS;
                slot = 0;
                last = BLOCK_SLOTS - 1;
            end
            else if (shadow_key[idx] != k)
            begin
                if (slot == last)
                begin
                    if (ids_used >= MAX_IDS || blocks_used >= POOL_BLOCKS)
                        return 1'b0;
                    // Move the old entry into a fresh block and add the new key after it.
                    nb = HASH_ENTRIES + blocks_used * BLOCK_SLOTS;
                    shadow_key[nb] = shadow_key[idx];
                    shadow_tag[nb] = tg;
                    shadow_key[nb + 1] = k;
                    shadow_tag[nb + 1] = TAG_W'(ids_used);
                    shadow_tag[nb + 2] = TAG_EMPTY;
                    id_to_key[ids_used] = k;
                    shadow_key[idx] = KEY_W'(blocks_used);
                    shadow_tag[idx] = TAG_LINK;
                    blocks_used++;
                    id_o = ID_W'(ids_used);
                    ids_used++;
                    fresh = 1'b1;
                    return 1'b1;
                end
                slot++;
            end
            else
            begin
                id_o = ID_W'(tg);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic id_result_t predict_result(input logic [1:0] op,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [ID_W-1:0] index);
        id_result_t r;
        r = '{default: '0};
        if (op == OP_MAP)
        begin
            if (!lookup_or_insert(k, r.id, r.is_new))
            begin
                r.id = '0;
                r.is_new = 1'b0;
                r.full_res = 1'b1;
            end
        end
        else if (op == OP_READ)
        begin
            if (int'(index) < ids_used)
                r.key_out = id_to_key[index];
        end
        else if (op == OP_CLEAR)
            shadow_clear();
        r.count = CNT_W'(ids_used);
        return r;
    endfunction

    // Offer one item, with a random idle gap when idling is on; record its result on accept.
    task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [ID_W-1:0] index);
        if (idle_on && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, index, k};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_result(op, k, index));
        @(negedge clk);
    endtask

    task automatic pause_item();
        s_tvalid <= 1'b0;
    endtask

    // Hold the sender until every expected result has come back.
    task automatic wait_drained();
        pause_item();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        send_item(OP_MAP, 24'h000000, 12'h000);
        send_item(OP_MAP, 24'hFFFFFF, 12'hFFF);
        send_item(OP_MAP, 24'h000000, 12'h000);       // seen key
        // Same head slot: grows a chain, fills a block, then links a second block.
        for (int n = 1; n <= 6; n++)
            send_item(OP_MAP, KEY_W'(n * HASH_ENTRIES), 12'h000);
        send_item(OP_MAP, KEY_W'(3 * HASH_ENTRIES), 12'h000);   // seen key deep in a chain
        send_item(OP_READ, 24'h000000, 12'h000);
        send_item(OP_READ, 24'h000000, 12'h007);
        send_item(OP_READ, 24'hFFFFFF, 12'h008);      // at count: reads back zero
        send_item(OP_READ, 24'h000000, 12'hFFF);      // far beyond count
        send_item(OP_NONE, 24'hFFFFFF, 12'hFFF);
        send_item(OP_CLEAR, 24'h123456, 12'h001);
        send_item(OP_READ, 24'h000000, 12'h000);      // nothing assigned after clear
        send_item(OP_MAP, 24'hFFFFFF, 12'h000);
        send_item(OP_MAP, 24'h5A5A5A, 12'hA5A);
        wait_drained();
    endtask

    // Crowd a few heads so chains run through several overflow blocks, then probe.
    task automatic test_chain_fill();
        send_item(OP_CLEAR, 24'h0, 12'h0);
        for (int n = 0; n < 400; n++)
            send_item(OP_MAP, KEY_W'(n % 16) | (KEY_W'($urandom_range(255)) << 12), 12'h0);
        send_item(OP_MAP, 24'hABCDEF, 12'h0);
        send_item(OP_READ, 24'h0, 12'h100);
        send_item(OP_READ, 24'h0, 12'h000);
        send_item(OP_READ, 24'h0, 12'hFFF);
        send_item(OP_CLEAR, 24'h0, 12'h0);
        wait_drained();
    endtask

    // Mostly maps over a reused key set so chains and repeats occur; some reads,
    // rare clears and unused opcodes.
    task automatic test_random(input int n_items);
        int pick;
        logic [KEY_W-1:0] k;
        logic [ID_W-1:0] index;
        for (int n = 0; n < n_items; n++)
        begin
            // Hold a long run with no idling on either side in the middle.
            idle_on = !(n >= n_items / 3 && n < n_items / 2);
            pick = $urandom_range(999);
            k = KEY_W'($urandom);
            index = ID_W'($urandom);
            if (pick < 600)
            begin
                if (recent_keys.size() != 0 && $urandom_range(2) == 0)
                    k = recent_keys[$urandom_range(recent_keys.size() - 1)];
                else if ($urandom_range(1) == 0)
                    k[HASH_W-1:0] = HASH_W'($urandom_range(7));   // crowd a few heads
                recent_keys.push_back(k);
                if (recent_keys.size() > 64)
                    void'(recent_keys.pop_front());
                send_item(OP_MAP, k, index);
            end
            else if (pick < 960)
            begin
                if (pick < 900 && ids_used > 0)
                    index = ID_W'($urandom_range(ids_used - 1));
                send_item(OP_READ, k, index);
            end
            else if (pick < 975)
            begin
                send_item(OP_CLEAR, k, index);
                recent_keys.delete();
            end
            else
                send_item(OP_NONE, k, index);
            if (n == n_items / 2)
                wait_drained();
        end
        idle_on = 1'b1;
    endtask

    // Receiver stalls at random, except during the quiet stretch.
    always @(negedge clk)
        m_tready <= idle_on ? ($urandom_range(99) >= 13) : 1'b1;

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        id_result_t want;
        id_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.id       = m_tdata[11:0];
            got.key_out  = m_tdata[35:12];
            got.is_new   = m_tdata[36];
            got.full_res = m_tdata[37];
            got.count    = m_tdata[50:38];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: id=%0d key_out=%h count=%0d",
                             got.id, got.key_out, got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp id=%0d key_out=%h new=%b full=%b cnt=%0d",
                                  " got id=%0d key_out=%h new=%b full=%b cnt=%0d"},
                                 want.id, want.key_out, want.is_new, want.full_res,
                                 want.count, got.id, got.key_out, got.is_new,
                                 got.full_res, got.count);
                end
            end
        end
    end

    // Stop a hung run: count cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        idle_on = 1'b1;
        shadow_clear();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_chain_fill();
        test_random(1525);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
